// ----- src/mwf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median window filter package
// Shared sizes, register indexes and types of the median window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 3;

  localparam int NLINES  = 2 * MAX_RADIUS;
  localparam int WSIDE   = 2 * MAX_RADIUS + 1;
  localparam int WCELLS  = WSIDE * WSIDE;
  localparam int MID     = (WCELLS - 1) / 2;
  localparam int RANK_W  = $clog2(WCELLS + 1);

  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int DIM_W   = 11;
  localparam int RAD_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [NLINES-1:0] lcol_t;   // [0] oldest line
  typedef pix_t [WCELLS-1:0] cells_t;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  rd_col;
    logic              wr;
    logic [COL_W-1:0]  wr_col;
    lcol_t             wr_data;
  } ls_ctrl_t;

  typedef struct packed {
    logic              emit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              done;
    logic [RAD_W-1:0]  rad;
  } meta_t;

  typedef struct packed {
    pix_t              median;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              done;
  } result_t;

endpackage

// ----- src/mwf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median window filter channels
// Pixel input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwf_pix_if import mwf_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface mwf_res_if import mwf_pkg::*; ();
  logic             valid;
  logic             ready;
  pix_t             median_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_done;

  modport source (output valid, median_value, out_row, out_col, frame_done, input ready);
  modport sink   (input valid, median_value, out_row, out_col, frame_done, output ready);
endinterface

// ----- src/median_window_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median window filter core
// Streaming 2-D median filter with line store, 7x7 window and rank selector.
// ----------------------------------------------------------------------------
// Usage:
//  pix_in carries grey pixels in raster order; frame_start on a beat puts it
//  at row 0, column 0. res_out carries one beat per pixel whose window of
//  side 2*radius+1 lies fully in the image: median, centre row/column, and
//  frame_done on the last one of the frame. Border pixels give no beat.
//  cfg_we/cfg_index/cfg_data write width, height and radius; write them only
//  while the filter is idle.
// Throughput: one pixel per clock while the result queue has space. The line
//  store is one column-wide memory read on the accept edge and written back
//  from the stage 1 registers; a bypass covers the same column coming back
//  (width one, restarted frame). A result passes store read, window shift,
//  compare matrix and rank count, then the result queue, to res_out.
// Stall: the pipeline moves as one while the two-entry result queue has
//  space, so a pixel is still taken while one result waits. With the queue
//  full, pix_in.ready drops and every stage holds.
// Reset: counters, window and queue clear; registers return to 1024x1024,
//  radius 1. The line store is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module median_window_filter_core import mwf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mwf_pix_if.sink               pix_in,
  mwf_res_if.source             res_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [RAD_W-1:0] radius;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [RAD_W-1:0] rad_eff;
  logic [DIM_W-1:0] side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(MAX_WIDTH);
      image_height <= DIM_W'(MAX_HEIGHT);
      radius       <= RAD_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_RADIUS: radius       <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  assign w_eff   = (image_width == '0) ? DIM_W'(1) :
                   (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
  assign h_eff   = (image_height == '0) ? DIM_W'(1) :
                   (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
  assign rad_eff = (radius == '0) ? RAD_W'(1) : radius;
  assign side2   = DIM_W'({rad_eff, 1'b0});

  // pipeline enable: queue has a free slot
  logic [1:0] q_cnt;
  logic       en;
  logic       acc;
  assign en           = (q_cnt != 2'd2);
  assign pix_in.ready = en;
  assign acc          = pix_in.valid && en;

  // position of the incoming pixel
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [DIM_W-1:0] row11;
  logic [DIM_W-1:0] col11;
  meta_t            meta0;

  assign cur_row = pix_in.frame_start ? '0 : row_count;
  assign cur_col = pix_in.frame_start ? '0 : col_count;
  assign row11   = DIM_W'(cur_row);
  assign col11   = DIM_W'(cur_col);

  always_comb begin
    meta0.emit = (row11 >= side2) && (row11 < h_eff) && (col11 >= side2) && (col11 < w_eff);
    meta0.row  = cur_row - ROW_W'(rad_eff);
    meta0.col  = cur_col - COL_W'(rad_eff);
    meta0.done = meta0.emit && (row11 == h_eff - 1'b1) && (col11 == w_eff - 1'b1);
    meta0.rad  = rad_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (acc) begin
      if (col11 + 1'b1 >= w_eff) begin
        col_count <= '0;
        row_count <= (row11 + 1'b1 >= h_eff) ? '0 : cur_row + 1'b1;
      end else begin
        col_count <= cur_col + 1'b1;
        row_count <= cur_row;
      end
    end
  end

  // stage 1: line store data arrives
  logic             p1_valid;
  pix_t             p1_px;
  logic [COL_W-1:0] p1_col;
  meta_t            p1_meta;
  ls_ctrl_t         ls_ctrl;
  lcol_t            ls_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_px   <= pix_in.pixel;
      p1_col  <= cur_col;
      p1_meta <= meta0;
    end
  end

  always_comb begin
    ls_ctrl.en      = en;
    ls_ctrl.rd_col  = cur_col;
    ls_ctrl.wr      = p1_valid;
    ls_ctrl.wr_col  = p1_col;
    // column moves up one line, new pixel at the bottom
    ls_ctrl.wr_data = {p1_px, ls_rd[NLINES-1:1]};
  end

  mwf_line_store u_line_store (
    .clk         (clk),
    .ctrl        (ls_ctrl),
    .rd_col_data (ls_rd)
  );

  // window: row WSIDE-1 is the current line, column WSIDE-1 the newest
  pix_t win [WSIDE][WSIDE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WSIDE; i++) begin
        for (int j = 0; j < WSIDE; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (en && p1_valid) begin
      for (int i = 0; i < WSIDE; i++) begin
        for (int j = 0; j < WSIDE - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][WSIDE-1] <= (i < NLINES) ? ls_rd[i] : p1_px;
      end
    end
  end

  // stage 2: window holds this item; unused cells padded 0/255 evenly
  logic   p2_valid, p3_valid, p4_valid;
  meta_t  p2_meta, p3_meta, p4_meta;
  cells_t cells;
  pix_t   median;

  always_comb begin
    int first;
    first = 2 * (MAX_RADIUS - int'(p2_meta.rad));
    for (int i = 0; i < WSIDE; i++) begin
      for (int j = 0; j < WSIDE; j++) begin
        if (i >= first && j >= first) begin
          cells[i*WSIDE+j] = win[i][j];
        end else begin
          cells[i*WSIDE+j] = ((i + j) % 2 == 1) ? '1 : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_meta <= p1_meta;
      p3_meta <= p2_meta;
      p4_meta <= p3_meta;
    end
  end

  mwf_median u_median (
    .clk    (clk),
    .en     (en),
    .cells  (cells),
    .median (median)
  );

  // result queue
  result_t q_data [2];
  logic    wr_ptr, rd_ptr;
  logic    push, pop;

  assign push = en && p4_valid && p4_meta.emit;
  assign pop  = res_out.valid && res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= '{median: median, row: p4_meta.row, col: p4_meta.col,
                          done: p4_meta.done};
    end
  end

  assign res_out.valid        = (q_cnt != 2'd0);
  assign res_out.median_value = q_data[rd_ptr].median;
  assign res_out.out_row      = q_data[rd_ptr].row;
  assign res_out.out_col      = q_data[rd_ptr].col;
  assign res_out.frame_done   = q_data[rd_ptr].done;

  // checks
  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_cnt <= 2'd2)
    else $error("result queue overflow");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      !en |=> $stable(p1_valid) && $stable(p4_valid))
    else $error("pipeline moved while stalled");

  a_done_emit: assert property (@(posedge clk) disable iff (rst)
      (p4_valid && p4_meta.done) |-> p4_meta.emit)
    else $error("frame end flagged on a border pixel");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
      (q_cnt == 2'd2) |-> !pix_in.ready)
    else $error("pixel taken with queue full");

endmodule

// ----- src/mwf_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median window filter line store
// One entry per column holding the last lines; read-modify-write with bypass.
// ----------------------------------------------------------------------------
module mwf_line_store import mwf_pkg::*; (
  input  logic     clk,
  input  ls_ctrl_t ctrl,
  output lcol_t    rd_col_data
);

  lcol_t mem [MAX_WIDTH];
  lcol_t rd_q;
  lcol_t fwd_data;
  logic  fwd_hit;

  always_ff @(posedge clk) begin
    if (ctrl.en && ctrl.wr) begin
      mem[ctrl.wr_col] <= ctrl.wr_data;
    end
    if (ctrl.en) begin
      rd_q     <= mem[ctrl.rd_col];
      // same column written on this edge: old read data is stale
      fwd_hit  <= ctrl.wr && (ctrl.wr_col == ctrl.rd_col);
      fwd_data <= ctrl.wr_data;
    end
  end

  assign rd_col_data = fwd_hit ? fwd_data : rd_q;

endmodule

// ----- src/mwf_median.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median window filter rank selector
// Two-stage rank count over the padded window; picks the middle ranked cell.
// ----------------------------------------------------------------------------
module mwf_median import mwf_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  cells_t cells,
  output pix_t   median
);

  logic [WCELLS-1:0] lt [WCELLS];
  logic [WCELLS-1:0] lt_next [WCELLS];
  cells_t            vals3;
  cells_t            vals4;
  logic [WCELLS-1:0] hit;
  logic [WCELLS-1:0] hit_next;

  // stable rank: ties broken by cell index
  always_comb begin
    for (int k = 0; k < WCELLS; k++) begin
      for (int j = 0; j < WCELLS; j++) begin
        lt_next[k][j] = (cells[j] < cells[k]) || ((j < k) && (cells[j] == cells[k]));
      end
    end
  end

  always_comb begin
    logic [RANK_W-1:0] cnt;
    for (int k = 0; k < WCELLS; k++) begin
      cnt = '0;
      for (int j = 0; j < WCELLS; j++) begin
        cnt = cnt + RANK_W'(lt[k][j]);
      end
      hit_next[k] = (cnt == RANK_W'(MID));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WCELLS; k++) begin
        lt[k] <= lt_next[k];
      end
      vals3 <= cells;
      vals4 <= vals3;
      hit   <= hit_next;
    end
  end

  always_comb begin
    median = '0;
    for (int k = 0; k < WCELLS; k++) begin
      median = median | (vals4[k] & {PIX_W{hit[k]}});
    end
  end

endmodule

// ----- tb/tb_median_window_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median window filter core testbench
// Streams pixel frames through the filter under random source bursts and
// sink stalls. A behavioural line store and window in the bench work out
// each median and its centre position. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_median_window_filter_core;
  import mwf_pkg::*;

  localparam int IDLE_LIMIT = 10000;   // cycles with no beat on either side
  localparam int SETTLE     = 12;      // pipeline depth plus margin

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mwf_pix_if pix ();
  mwf_res_if res ();

  median_window_filter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix),
    .res_out   (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // --------------------------------------------------------------------------
  // Filter prediction: shadow of the line store, window, counters, registers
  // --------------------------------------------------------------------------
  pix_t             line_mem [NLINES][MAX_WIDTH];
  pix_t             win_mem  [WSIDE][WSIDE];
  int unsigned      row_pos, col_pos;
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [RAD_W-1:0] radius_reg;
  result_t          median_q [$];   // medians still owed by the filter

  bit               failed;
  int               mismatches;

  task automatic predict_median(input pix_t p, input logic fs);
    int unsigned w, h, rd, row, col, first;
    pix_t        cells [$];
    result_t     r;
    w  = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h  = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    rd = (radius_reg == 0) ? 1 : (radius_reg > MAX_RADIUS ? MAX_RADIUS : radius_reg);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    row = row_pos;
    col = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    // window slides left; new column is the stored lines plus this pixel
    for (int i = 0; i < WSIDE; i++) begin
      for (int j = 0; j < WSIDE - 1; j++) win_mem[i][j] = win_mem[i][j+1];
      win_mem[i][WSIDE-1] = (i < NLINES) ? line_mem[i][col] : p;
    end
    for (int i = 0; i < NLINES - 1; i++) line_mem[i][col] = line_mem[i+1][col];
    line_mem[NLINES-1][col] = p;
    if (row >= 2*rd && row < h && col >= 2*rd && col < w) begin
      first = WSIDE - (2*rd + 1);
      for (int i = first; i < WSIDE; i++)
        for (int j = first; j < WSIDE; j++) cells.push_back(win_mem[i][j]);
      cells.sort();
      r.median = cells[cells.size()/2];
      r.row    = ROW_W'(row - rd);
      r.col    = COL_W'(col - rd);
      r.done   = (row == h - 1 && col == w - 1);
      median_q.push_back(r);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // pixel beats feed the prediction; values sampled before the edge updates
  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready) predict_median(pix.pixel, pix.frame_start);
  end

  // result beats against the oldest owed median
  always @(posedge clk) begin
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (median_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: median %0d row %0d col %0d done %0b",
                   res.median_value, res.out_row, res.out_col, res.frame_done);
      end else begin
        want = median_q.pop_front();
        if (res.median_value !== want.median || res.out_row !== want.row ||
            res.out_col !== want.col || res.frame_done !== want.done) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp median %0d row %0d col %0d done %0b, got %0d %0d %0d %0b",
                     want.median, want.row, want.col, want.done,
                     res.median_value, res.out_row, res.out_col, res.frame_done);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink side: stall pattern changes every so often; a hold request forces a
  // long stretch of ready low so the result queue fills and pix_in backs up.
  // --------------------------------------------------------------------------
  bit hold_req;
  int hold_left;
  int sink_mode, mode_left;

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (hold_req) begin
        hold_req  = 0;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        case (sink_mode)
          0: res.ready <= 1'b1;
          1: res.ready <= ($urandom_range(0, 9) < 7);
          default: res.ready <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // watchdog: no beat on either channel for too long
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[median_window_filter_core] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Source side helpers
  // --------------------------------------------------------------------------
  int burst_left;

  // one pixel beat; returns on the accepting edge with valid still high
  task automatic send_pixel(input pix_t p, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    pix.valid       <= 1'b1;
    pix.pixel       <= p;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
    burst_left--;
  endtask

  // source quiet until every owed median is back, then let the pipe settle
  task automatic wait_drained();
    pix.valid <= 1'b0;
    do @(posedge clk); while (median_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    case (idx)
      REG_WIDTH:  width_reg  = DIM_W'(val);
      REG_HEIGHT: height_reg = DIM_W'(val);
      default:    radius_reg = RAD_W'(val);
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned r);
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // n random pixels of a frame; frame_start on the first only if mark_start is set
  task automatic send_frame(input int unsigned n, input bit mark_start);
    for (int unsigned k = 0; k < n; k++)
      send_pixel(pix_t'($urandom), (k == 0) && mark_start);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // 5x5, radius 1: pixel extremes and a mixed patch, nine medians
  task automatic test_extremes();
    pix_t pat [25];
    set_config(5, 5, 1);
    foreach (pat[k]) pat[k] = (k % 3 == 0) ? 8'd255 : ((k % 3 == 1) ? 8'd0 : pix_t'(k * 37));
    foreach (pat[k]) send_pixel(pat[k], k == 0);
    // radius zero falls back to one: single median in a 3x3 frame
    set_config(3, 3, 0);
    send_frame(9, 1);
    // largest window just fits a 7x7 frame
    set_config(7, 7, 3);
    send_frame(49, 1);
  endtask

  // zero width/height read as one: no windows fit, nothing comes out
  task automatic test_narrow();
    set_config(0, 9, 1);
    send_frame(12, 1);
    set_config(6, 0, 2);
    send_frame(12, 1);
    set_config(6, 6, 3);   // side 7 exceeds the image
    send_frame(36, 1);
  endtask

  // long rows on a three-line image, frame_done at the far column
  task automatic test_full_width();
    set_config(48, 3, 1);
    send_frame(3 * 48, 1);
  endtask

  // many rows on a three-column image, frame_done on the last row
  task automatic test_full_height();
    set_config(3, 48, 1);
    send_frame(3 * 48, 1);
  endtask

  // sink holds off for a long stretch while the source keeps offering
  task automatic test_backpressure();
    set_config(8, 8, 1);
    hold_req = 1;
    send_frame(64, 1);
    send_frame(64, 1);
  endtask

  // random settings; mostly whole frames, some wrapping without
  // frame_start, some cut short by an early restart
  task automatic test_random_frames();
    int unsigned sent, rd, w, h, n;
    bit          whole;
    sent = 0;
    while (sent < 200) begin
      rd = $urandom_range(1, 3);
      w  = $urandom_range(2*rd + 1, 2*rd + 10);
      h  = $urandom_range(2*rd + 1, 2*rd + 5);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(1, 2*rd);   // narrow noise
      set_config(w, h, ($urandom_range(0, 5) == 0 && rd == 1) ? 0 : rd);
      whole = 0;
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 5))
          0: n = $urandom_range(1, w * h - 1);   // abandoned frame
          1: n = w * h;
          default: n = w * h;
        endcase
        // a frame may follow a whole one by the row wrap alone
        send_frame(n, !(whole && $urandom_range(0, 2) == 0));
        whole = (n == w * h);
        sent += n;
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    pix.valid       = 1'b0;
    pix.pixel       = '0;
    pix.frame_start = 1'b0;
    res.ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_WIDTH;
    cfg_data        = '0;
    failed          = 0;
    mismatches      = 0;
    hold_req        = 0;
    burst_left      = 0;
    row_pos         = 0;
    col_pos         = 0;
    width_reg       = DIM_W'(MAX_WIDTH);
    height_reg      = DIM_W'(MAX_HEIGHT);
    radius_reg      = RAD_W'(1);
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win_mem[i, j]) win_mem[i][j] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_narrow();
    test_backpressure();
    test_full_width();
    test_full_height();
    test_random_frames();
    wait_drained();

    if (!failed && median_q.size() == 0) begin
      $display("[median_window_filter_core] OK");
    end else begin
      $display("[median_window_filter_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mwf_pkg.sv
src/mwf_if.sv
src/mwf_line_store.sv
src/mwf_median.sv
src/median_window_filter_core.sv
tb/tb_median_window_filter_core.sv
